@@ sv/rfc_pkg.sv @@
`timescale 1ns / 1ps

package rfc_pkg;

  localparam int WordW    = 40;
  localparam int ChipIdW  = 17;
  localparam int BunchW   = 12;
  localparam int CrcW     = 8;
  localparam int CountW   = 8;
  localparam int CrcInW   = CrcW + WordW;

  localparam logic [14:0]        SyncPattern = 15'h3C5C;
  localparam logic [1:0]         SyncHeader  = 2'd0;
  localparam logic [CrcW-1:0]    CrcPoly     = 8'h2F;
  localparam logic [ChipIdW-1:0] ChipIdReset = 17'h1ABCD;
  localparam logic [CountW-1:0]  CountMax    = 8'hFF;

  typedef logic [CrcW-1:0] crc_cols_t [CrcInW];

  typedef struct packed {
    logic [CrcW-1:0]   crc_computed;
    logic [CrcW-1:0]   crc_received;
    logic              crc_error;
    logic              bunch_mismatch;
    logic              reportable_error;
    logic [CountW-1:0] data_word_count;
    logic [7:0]        trailer_hit_count;
    logic [BunchW-1:0] header_bunch_id;
  } rfc_result_t;

  // Each entry is the CRC contribution of one input bit: entries below CrcW
  // are the bits of the incoming CRC, the rest are the bits of the data word.
  function automatic crc_cols_t crc_make_cols(input int nbytes);
    crc_cols_t       cols;
    logic [CrcW-1:0] c;
    logic [WordW-1:0] d;
    logic            fb;
    for (int p = 0; p < CrcInW; p++) begin
      c = '0;
      d = '0;
      if (p < CrcW) begin
        c[p] = 1'b1;
      end else begin
        d[p-CrcW] = 1'b1;
      end
      for (int i = nbytes * 8 - 1; i >= 0; i--) begin
        fb = c[CrcW-1] ^ d[i];
        c  = {c[CrcW-2:0], 1'b0};
        if (fb) begin
          c = c ^ CrcPoly;
        end
      end
      cols[p] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t Crc5Cols = crc_make_cols(5);
  localparam crc_cols_t Crc4Cols = crc_make_cols(4);

  function automatic logic [CrcW-1:0] crc_apply(input crc_cols_t cols,
                                                input logic [CrcW-1:0] crc,
                                                input logic [WordW-1:0] data);
    logic [CrcW-1:0]   acc;
    logic [CrcInW-1:0] v;
    v   = {data, crc};
    acc = '0;
    for (int p = 0; p < CrcInW; p++) begin
      if (v[p]) begin
        acc = acc ^ cols[p];
      end
    end
    return acc;
  endfunction

endpackage

@@ sv/readout_frame_crc_checker_top.sv @@
`timescale 1ns / 1ps

// Frame checker for a 40-bit readout link. One frame word is taken per clock
// cycle unless a result request waits on a stalled output. A word is registered
// on the way in, then classified and folded into the event CRC there, and a
// trailer's result request is then registered. The event state and the 8-bit
// CRC update are a single register stage, which sets the rate at one word per
// cycle. Headers, data, fillers and wrong-chip trailers give no result request.
// The expected chip id may only be changed while no words are in flight.

module readout_frame_crc_checker_top
  import rfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WordW-1:0]   in_frame_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CrcW-1:0]    out_crc_computed,
  output logic [CrcW-1:0]    out_crc_received,
  output logic               out_crc_error,
  output logic               out_bunch_mismatch,
  output logic               out_reportable_error,
  output logic [CountW-1:0]  out_data_word_count,
  output logic [7:0]         out_trailer_hit_count,
  output logic [BunchW-1:0]  out_header_bunch_id,
  input  logic               cfg_we,
  input  logic [ChipIdW-1:0] cfg_wdata
);

  logic               s1_vld_r;
  logic [WordW-1:0]   s1_word_r;
  logic               out_vld_r;
  rfc_result_t        out_res_r;
  logic [ChipIdW-1:0] chip_id_r;

  logic        res_hit;
  rfc_result_t res;
  logic        out_free;
  logic        s1_go;

  rfc_event u_event (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_go),
    .word    (s1_word_r),
    .chip_id (chip_id_r),
    .res_hit (res_hit),
    .res     (res)
  );

  assign out_free = !out_vld_r || out_ready;
  assign s1_go    = s1_vld_r && (!res_hit || out_free);
  assign in_ready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      chip_id_r <= ChipIdReset;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_go && res_hit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        chip_id_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_frame_word;
    end
    if (s1_go && res_hit) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_crc_computed      = out_res_r.crc_computed;
  assign out_crc_received      = out_res_r.crc_received;
  assign out_crc_error         = out_res_r.crc_error;
  assign out_bunch_mismatch    = out_res_r.bunch_mismatch;
  assign out_reportable_error  = out_res_r.reportable_error;
  assign out_data_word_count   = out_res_r.data_word_count;
  assign out_trailer_hit_count = out_res_r.trailer_hit_count;
  assign out_header_bunch_id   = out_res_r.header_bunch_id;

endmodule

@@ sv/rfc_crc_calc.sv @@
`timescale 1ns / 1ps

module rfc_crc_calc
  import rfc_pkg::*;
(
  input  logic [CrcW-1:0]  crc_in,
  input  logic [WordW-1:0] word,
  output logic [CrcW-1:0]  crc_head,
  output logic [CrcW-1:0]  crc_data,
  output logic [CrcW-1:0]  crc_trail
);

  logic [WordW-1:0] trail_bytes;

  assign trail_bytes = {8'b0, word[WordW-1:8]};

  assign crc_head  = crc_apply(Crc5Cols, '0, word);
  assign crc_data  = crc_apply(Crc5Cols, crc_in, word);
  assign crc_trail = crc_apply(Crc4Cols, crc_in, trail_bytes);

endmodule

@@ sv/rfc_event.sv @@
`timescale 1ns / 1ps

module rfc_event
  import rfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [WordW-1:0]   word,
  input  logic [ChipIdW-1:0] chip_id,
  output logic               res_hit,
  output rfc_result_t        res
);

  logic              open_r, open_nxt;
  logic [BunchW-1:0] bunch_r, bunch_nxt;
  logic [CrcW-1:0]   crc_r, crc_nxt;
  logic              mis_r, mis_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;

  logic            is_data;
  logic            is_sync;
  logic            hdr_word;
  logic [CrcW-1:0] crc_head;
  logic [CrcW-1:0] crc_data;
  logic [CrcW-1:0] crc_trail;
  logic            crc_err;

  rfc_crc_calc u_crc (
    .crc_in    (crc_r),
    .word      (word),
    .crc_head  (crc_head),
    .crc_data  (crc_data),
    .crc_trail (crc_trail)
  );

  assign is_data   = word[WordW-1];
  assign is_sync   = !is_data && (word[38:24] == SyncPattern);
  assign hdr_word  = is_sync && (word[23:22] == SyncHeader);
  assign res_hit   = !is_data && !is_sync && (word[38:22] == chip_id) && open_r;
  assign crc_err   = (crc_trail != word[7:0]);

  always_comb begin
    res.crc_computed      = crc_trail;
    res.crc_received      = word[7:0];
    res.crc_error         = crc_err;
    res.bunch_mismatch    = mis_r;
    res.reportable_error  = crc_err && !mis_r;
    res.data_word_count   = cnt_r;
    res.trailer_hit_count = word[15:8];
    res.header_bunch_id   = bunch_r;
  end

  always_comb begin
    open_nxt  = open_r;
    bunch_nxt = bunch_r;
    crc_nxt   = crc_r;
    mis_nxt   = mis_r;
    cnt_nxt   = cnt_r;
    if (fire) begin
      priority if (hdr_word) begin
        open_nxt  = 1'b1;
        bunch_nxt = word[BunchW-1:0];
        crc_nxt   = crc_head;
        mis_nxt   = 1'b0;
        cnt_nxt   = '0;
      end else if (is_data && open_r) begin
        crc_nxt = crc_data;
        mis_nxt = mis_r || (word[20:9] != bunch_r);
        if (cnt_r != CountMax) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (res_hit) begin
        crc_nxt  = crc_trail;
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      bunch_r <= '0;
      crc_r   <= '0;
      mis_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      open_r  <= open_nxt;
      bunch_r <= bunch_nxt;
      crc_r   <= crc_nxt;
      mis_r   <= mis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/rfc_checker.sv @@
`timescale 1ns / 1ps

module rfc_checker
  import rfc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CrcW-1:0]   out_crc_computed,
  input logic [CrcW-1:0]   out_crc_received,
  input logic              out_crc_error,
  input logic              out_bunch_mismatch,
  input logic              out_reportable_error,
  input logic [CountW-1:0] out_data_word_count
);

  // A stalled result request keeps its valid and its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_crc_computed)
      && $stable(out_crc_received) && $stable(out_data_word_count))
    else $error("stalled result request changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_crc_error == (out_crc_computed != out_crc_received))
    else $error("crc error flag disagrees with the compared bytes");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reportable_error == (out_crc_error && !out_bunch_mismatch))
    else $error("reportable error flag inconsistent");

  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result request present right after reset");

endmodule

bind readout_frame_crc_checker_top rfc_checker u_rfc_checker (.*);

@@ dv/rfc_event_checker.sv @@
`timescale 1ns / 1ps

package frame_crc_tb_pkg;

  import rfc_pkg::*;

  function automatic logic [CrcW-1:0] crc8_fold(input logic [CrcW-1:0] crc,
                                                input logic [WordW-1:0] data,
                                                input int nbytes);
    logic [CrcW-1:0] c;
    int i;
    int k;
    c = crc;
    for (i = nbytes - 1; i >= 0; i--) begin
      c = c ^ data[i*8 +: 8];
      for (k = 0; k < 8; k++) begin
        if (c[CrcW-1]) begin
          c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
        end else begin
          c = {c[CrcW-2:0], 1'b0};
        end
      end
    end
    return c;
  endfunction

endpackage

module rfc_event_checker
  import rfc_pkg::*;
  import frame_crc_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [WordW-1:0]   in_frame_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CrcW-1:0]    out_crc_computed,
  input  logic [CrcW-1:0]    out_crc_received,
  input  logic               out_crc_error,
  input  logic               out_bunch_mismatch,
  input  logic               out_reportable_error,
  input  logic [CountW-1:0]  out_data_word_count,
  input  logic [7:0]         out_trailer_hit_count,
  input  logic [BunchW-1:0]  out_header_bunch_id,
  input  logic               cfg_we,
  input  logic [ChipIdW-1:0] cfg_wdata,
  output int                 mismatch_count,
  output int                 awaiting
);

  typedef enum logic [1:0] {
    WORD_DATA,
    WORD_HEADER,
    WORD_OTHER_SYNC,
    WORD_TRAILER
  } word_kind_t;

  logic [ChipIdW-1:0] chip_id_q;
  logic               evt_open;
  logic [BunchW-1:0]  evt_bunch;
  logic [CrcW-1:0]    evt_crc;
  logic               evt_mismatch;
  logic [CountW-1:0]  evt_count;
  rfc_result_t        reports_due[$];
  int                 errs;

  assign mismatch_count = errs;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errs++;
  endtask

  task automatic predict_word(input logic [WordW-1:0] w);
    word_kind_t  kind;
    rfc_result_t r;
    if (w[39]) begin
      kind = WORD_DATA;
    end else if (w[38:24] == SyncPattern) begin
      kind = (w[23:22] == SyncHeader) ? WORD_HEADER : WORD_OTHER_SYNC;
    end else begin
      kind = WORD_TRAILER;
    end
    case (kind)
      WORD_DATA: begin
        if (evt_open) begin
          evt_crc = crc8_fold(evt_crc, w, 5);
          if (w[20:9] != evt_bunch) begin
            evt_mismatch = 1'b1;
          end
          if (evt_count != CountMax) begin
            evt_count = evt_count + 1'b1;
          end
        end
      end
      WORD_HEADER: begin
        evt_open     = 1'b1;
        evt_crc      = crc8_fold('0, w, 5);
        evt_bunch    = w[11:0];
        evt_mismatch = 1'b0;
        evt_count    = '0;
      end
      WORD_TRAILER: begin
        if ((w[38:22] == chip_id_q) && evt_open) begin
          r.crc_computed      = crc8_fold(evt_crc, w >> 8, 4);
          r.crc_received      = w[7:0];
          r.crc_error         = (r.crc_computed != r.crc_received);
          r.bunch_mismatch    = evt_mismatch;
          r.reportable_error  = r.crc_error && !evt_mismatch;
          r.data_word_count   = evt_count;
          r.trailer_hit_count = w[15:8];
          r.header_bunch_id   = evt_bunch;
          reports_due.insert(reports_due.size(), r);
          evt_crc  = r.crc_computed;
          evt_open = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_result();
    rfc_result_t want;
    if (reports_due.size() == 0) begin
      report_mismatch($sformatf("result request with none due, crc %0h",
                                out_crc_computed));
    end else begin
      want = reports_due.pop_front();
      if (out_crc_computed !== want.crc_computed) begin
        report_mismatch($sformatf("crc_computed got %0h want %0h",
                                  out_crc_computed, want.crc_computed));
      end
      if (out_crc_received !== want.crc_received) begin
        report_mismatch($sformatf("crc_received got %0h want %0h",
                                  out_crc_received, want.crc_received));
      end
      if (out_crc_error !== want.crc_error) begin
        report_mismatch($sformatf("crc_error got %0b want %0b",
                                  out_crc_error, want.crc_error));
      end
      if (out_bunch_mismatch !== want.bunch_mismatch) begin
        report_mismatch($sformatf("bunch_mismatch got %0b want %0b",
                                  out_bunch_mismatch, want.bunch_mismatch));
      end
      if (out_reportable_error !== want.reportable_error) begin
        report_mismatch($sformatf("reportable_error got %0b want %0b",
                                  out_reportable_error, want.reportable_error));
      end
      if (out_data_word_count !== want.data_word_count) begin
        report_mismatch($sformatf("data_word_count got %0d want %0d",
                                  out_data_word_count, want.data_word_count));
      end
      if (out_trailer_hit_count !== want.trailer_hit_count) begin
        report_mismatch($sformatf("trailer_hit_count got %0h want %0h",
                                  out_trailer_hit_count, want.trailer_hit_count));
      end
      if (out_header_bunch_id !== want.header_bunch_id) begin
        report_mismatch($sformatf("header_bunch_id got %0h want %0h",
                                  out_header_bunch_id, want.header_bunch_id));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chip_id_q    = ChipIdReset;
      evt_open     = 1'b0;
      evt_bunch    = '0;
      evt_crc      = '0;
      evt_mismatch = 1'b0;
      evt_count    = '0;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        chip_id_q = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        compare_result();
      end
      if (in_valid && in_ready) begin
        predict_word(in_frame_word);
      end
    end
    awaiting <= reports_due.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  import rfc_pkg::*;
  import frame_crc_tb_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseWords  = 180;
  localparam int NumPhases   = 5;
  localparam int HoldCycles  = 300;
  localparam int DrainLimit  = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [WordW-1:0]   in_frame_word;
  logic               out_valid;
  logic               out_ready;
  logic [CrcW-1:0]    out_crc_computed;
  logic [CrcW-1:0]    out_crc_received;
  logic               out_crc_error;
  logic               out_bunch_mismatch;
  logic               out_reportable_error;
  logic [CountW-1:0]  out_data_word_count;
  logic [7:0]         out_trailer_hit_count;
  logic [BunchW-1:0]  out_header_bunch_id;
  logic               cfg_we;
  logic [ChipIdW-1:0] cfg_wdata;

  int                 mismatch_count;
  int                 awaiting;
  int                 cycles;
  int                 event_words;
  bit                 calm;
  bit                 hold_out;
  logic [ChipIdW-1:0] gen_chip;
  logic [CrcW-1:0]    gen_crc;
  logic [BunchW-1:0]  gen_bunch;

  readout_frame_crc_checker_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_frame_word         (in_frame_word),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_crc_computed      (out_crc_computed),
    .out_crc_received      (out_crc_received),
    .out_crc_error         (out_crc_error),
    .out_bunch_mismatch    (out_bunch_mismatch),
    .out_reportable_error  (out_reportable_error),
    .out_data_word_count   (out_data_word_count),
    .out_trailer_hit_count (out_trailer_hit_count),
    .out_header_bunch_id   (out_header_bunch_id),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  rfc_event_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_frame_word         (in_frame_word),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_crc_computed      (out_crc_computed),
    .out_crc_received      (out_crc_received),
    .out_crc_error         (out_crc_error),
    .out_bunch_mismatch    (out_bunch_mismatch),
    .out_reportable_error  (out_reportable_error),
    .out_data_word_count   (out_data_word_count),
    .out_trailer_hit_count (out_trailer_hit_count),
    .out_header_bunch_id   (out_header_bunch_id),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .mismatch_count        (mismatch_count),
    .awaiting              (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver takes one long hold-off on request, else idles at random unless calm.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] make_header(input logic [BunchW-1:0] b);
    return {1'b0, SyncPattern, SyncHeader, 10'($urandom()), b};
  endfunction

  function automatic logic [WordW-1:0] make_sync(input logic [1:0] kind);
    return {1'b0, SyncPattern, kind, 22'($urandom())};
  endfunction

  function automatic logic [WordW-1:0] make_data(input logic [BunchW-1:0] b);
    return {1'b1, 18'($urandom()), b, 9'($urandom())};
  endfunction

  function automatic logic [WordW-1:0] make_trailer(input logic [ChipIdW-1:0] chip,
                                                    input logic [7:0] hits,
                                                    input logic [7:0] low);
    return {1'b0, chip, 6'($urandom()), hits, low};
  endfunction

  task automatic send_word(input logic [WordW-1:0] w);
    if (!calm && ($urandom_range(99) < 7)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_frame_word <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic send_header(input logic [WordW-1:0] w);
    send_word(w);
    gen_bunch = w[11:0];
    gen_crc   = crc8_fold('0, w, 5);
  endtask

  task automatic send_data(input logic [WordW-1:0] w);
    send_word(w);
    gen_crc = crc8_fold(gen_crc, w, 5);
  endtask

  task automatic send_trailer(input bit good, input logic [7:0] hits);
    logic [WordW-1:0] t;
    logic [CrcW-1:0]  c;
    t = make_trailer(gen_chip, hits, 8'h00);
    c = crc8_fold(gen_crc, t >> 8, 4);
    t[7:0] = good ? c : (c ^ 8'($urandom_range(1, 255)));
    send_word(t);
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_word(rand_word());
      1: send_word(make_data(12'($urandom())));
      2: send_word(make_trailer(gen_chip, 8'($urandom()), 8'($urandom())));
      default: send_word(make_sync(2'($urandom_range(1, 3))));
    endcase
  endtask

  task automatic run_event();
    int n;
    int i;
    int sel;
    logic [BunchW-1:0] b;
    send_header(make_header(12'($urandom())));
    n = ($urandom_range(99) < 1) ? $urandom_range(250, 300) : $urandom_range(0, 8);
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        send_header(make_header(12'($urandom())));
      end else if (sel < 7) begin
        send_word(make_sync(2'($urandom_range(1, 3))));
      end else if (sel < 11) begin
        send_word(make_trailer(gen_chip ^ (17'd1 << $urandom_range(0, 16)),
                               8'($urandom()), 8'($urandom())));
      end else begin
        b = ($urandom_range(99) < 8) ? 12'($urandom()) : gen_bunch;
        send_data(make_data(b));
      end
    end
    send_trailer($urandom_range(99) < 75, 8'($urandom()));
    event_words = event_words + n + 2;
  endtask

  task automatic drain_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((awaiting != 0) && (waited < DrainLimit));
    repeat (8) @(posedge clk);
  endtask

  task automatic set_chip(input logic [ChipIdW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_chip  = v;
  endtask

  initial begin
    int phase;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_frame_word = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    hold_out      = 1'b0;
    gen_chip      = ChipIdReset;
    gen_crc       = '0;
    gen_bunch     = '0;
    event_words   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_trailer(gen_chip, 8'h12, 8'h34));
    send_word(40'hFF_FFFF_FFFF);
    send_header({1'b0, SyncPattern, SyncHeader, 22'h00_0000});
    send_data(40'h80_0000_0000);
    send_data(40'hFF_FFFF_FFFF);
    send_word(make_sync(2'd2));
    send_word(make_sync(2'd1));
    send_word(make_sync(2'd3));
    send_word(make_trailer(gen_chip ^ 17'h1, 8'h00, 8'h00));
    send_trailer(1'b1, 8'h00);
    send_header({1'b0, SyncPattern, SyncHeader, 22'h3F_FFFF});
    send_data(40'hFF_FFFF_FFFF);
    send_header(make_header(12'h5A5));
    send_data(make_data(12'h5A5));
    send_trailer(1'b0, 8'hFF);
    send_header(make_header(12'h000));
    send_trailer(1'b1, 8'hA5);
    send_header(make_header(12'hFFF));
    send_trailer(1'b0, 8'h5A);
    send_word(40'h00_0000_0000);
    send_word(40'h7F_FFFF_FFFF);
    drain_results();

    for (phase = 1; phase <= NumPhases; phase++) begin
      case (phase)
        1: set_chip(17'h0_0000);
        2: set_chip(17'h1_FFFF);
        NumPhases: set_chip(ChipIdReset);
        default: set_chip(17'($urandom()));
      endcase
      calm = (phase == 2);
      if (phase == 3) begin
        hold_out = 1'b1;
      end
      event_words = 0;
      while (event_words < PhaseWords) begin
        if ($urandom_range(99) < 20) begin
          send_noise();
        end
        run_event();
      end
      drain_results();
    end

    if ((mismatch_count == 0) && (awaiting == 0)) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
